/* rtl/tclc_pkg.sv */
// tclc_pkg: shared constants and types for the two-color Life column stepper.
// Used by tclc_lane, tclc_column and two_color_life_column_step.
package tclc_pkg;

    // Board geometry and field widths
    localparam int ROWS        = 16;
    localparam int COL_W       = 16;
    localparam int ROUND_W     = 10;
    localparam int NROUND_W    = 11;
    localparam int IN_W        = 48;
    localparam int OUT_W       = 48;

    // Result queue: one item yields at most two results
    localparam int MAX_RES     = 2;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int FIFO_CW     = 3;

    localparam logic [ROUND_W-1:0] MAX_ROUNDS_RST = 10'd100;

    typedef enum logic [1:0] {
        WIN_NONE = 2'd0,
        WIN_GOOD = 2'd1,
        WIN_BAD  = 2'd2,
        WIN_DRAW = 2'd3
    } t_winner;

    // Neighbourhood of one cell: three columns, rows r-1..r+1 (bit 0 is r-1)
    typedef struct packed {
        logic [2:0] left_all;
        logic [2:0] left_good;
        logic [1:0] mid_all;
        logic [1:0] mid_good;
        logic [2:0] right_all;
        logic [2:0] right_good;
        logic       self_good;
        logic       self_bad;
    } t_nbhd;

    // One result item
    typedef struct packed {
        logic [COL_W-1:0]    good;
        logic [COL_W-1:0]    bad;
        logic                last;
        t_winner             winner;
        logic [NROUND_W-1:0] next_round;
        logic                next_player;
    } t_result;

endpackage

/* rtl/tclc_lane.sv */
// tclc_lane: next state of one cell from its 3x3 neighbourhood.
// Depends on tclc_pkg (t_nbhd).
module tclc_lane (
    input  tclc_pkg::t_nbhd i_nbhd,
    output logic            o_good,
    output logic            o_bad
);

    logic [7:0] all_bits;
    logic [7:0] good_bits;
    logic [3:0] live;
    logic [3:0] good;

    // Count live and good neighbours
    assign all_bits  = {i_nbhd.left_all, i_nbhd.mid_all, i_nbhd.right_all};
    assign good_bits = {i_nbhd.left_good, i_nbhd.mid_good, i_nbhd.right_good};
    assign live      = 4'($countones(all_bits));
    assign good      = 4'($countones(good_bits));

    // Apply survive and birth rules; a cell both good and bad dies
    always_comb begin
        o_good = 1'b0;
        o_bad  = 1'b0;
        if (i_nbhd.self_good || i_nbhd.self_bad) begin
            if ((live == 4'd2 || live == 4'd3) && !(i_nbhd.self_good && i_nbhd.self_bad)) begin
                o_good = i_nbhd.self_good;
                o_bad  = !i_nbhd.self_good;
            end
        end else if (live == 4'd3) begin
            if (good >= 4'd2) begin
                o_good = 1'b1;
            end else begin
                o_bad = 1'b1;
            end
        end
    end

endmodule

/* rtl/tclc_column.sv */
// tclc_column: one lane per row computing the next generation of a column.
// Depends on tclc_pkg and tclc_lane.
module tclc_column (
    input  logic [tclc_pkg::ROWS-1:0] i_left_good,
    input  logic [tclc_pkg::ROWS-1:0] i_left_bad,
    input  logic [tclc_pkg::ROWS-1:0] i_mid_good,
    input  logic [tclc_pkg::ROWS-1:0] i_mid_bad,
    input  logic [tclc_pkg::ROWS-1:0] i_right_good,
    input  logic [tclc_pkg::ROWS-1:0] i_right_bad,
    output logic [tclc_pkg::ROWS-1:0] o_good,
    output logic [tclc_pkg::ROWS-1:0] o_bad
);

    // Pad each column with a dead row above and below the board
    logic [tclc_pkg::ROWS+1:0] la_x, lg_x, ma_x, mg_x, ra_x, rg_x;

    assign la_x = {1'b0, i_left_good | i_left_bad, 1'b0};
    assign lg_x = {1'b0, i_left_good, 1'b0};
    assign ma_x = {1'b0, i_mid_good | i_mid_bad, 1'b0};
    assign mg_x = {1'b0, i_mid_good, 1'b0};
    assign ra_x = {1'b0, i_right_good | i_right_bad, 1'b0};
    assign rg_x = {1'b0, i_right_good, 1'b0};

    // One lane per row
    for (genvar r = 0; r < tclc_pkg::ROWS; r++) begin : g_lane
        tclc_pkg::t_nbhd nb;

        assign nb.left_all   = la_x[r+2:r];
        assign nb.left_good  = lg_x[r+2:r];
        assign nb.mid_all    = {ma_x[r+2], ma_x[r]};
        assign nb.mid_good   = {mg_x[r+2], mg_x[r]};
        assign nb.right_all  = ra_x[r+2:r];
        assign nb.right_good = rg_x[r+2:r];
        assign nb.self_good  = i_mid_good[r];
        assign nb.self_bad   = i_mid_bad[r];

        tclc_lane u_lane (
            .i_nbhd (nb),
            .o_good (o_good[r]),
            .o_bad  (o_bad[r])
        );
    end

endmodule

/* rtl/two_color_life_column_step.sv */
// two_color_life_column_step: streams a board column by column and emits
// the next generation. Depends on tclc_pkg and tclc_column.
//
// Channel  | Dir | Handshake                     | Payload (low bit first)
// ---------+-----+-------------------------------+--------------------------------
// s_axis   | in  | tvalid/tready                 | tdata: good, bad, round, player
//          |     |                               | tlast: last column
// m_axis   | out | tvalid/tready                 | tdata: next good, next bad,
//          |     |                               | winner, next round, next player
//          |     |                               | tlast: final column
// cfg      | in  | i_cfg_we                      | i_cfg_wdata: max rounds
//
// An input column is evaluated in the cycle of its transfer; its zero, one or
// two results are registered in a four-entry result queue and shown from its head.
// One column per cycle is sustained while the consumer takes one result per
// cycle; a last column adds a second result.
// s_axis_tready is high while the queue holds two results or fewer.
// Reset (synchronous, active low) empties the window, the seen flags and the
// queue and sets max rounds to 100.
module two_color_life_column_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tclc_pkg::ROUND_W-1:0]  i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [15:0] good_column, [31:16] bad_column, [41:32] round_number,
    // [42] side_to_move, [47:43] zero
    input  logic [tclc_pkg::IN_W-1:0]     s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [15:0] next_good_column, [31:16] next_bad_column, [33:32] winner,
    // [44:34] next_round, [45] next_player, [47:46] zero
    output logic [tclc_pkg::OUT_W-1:0]    m_axis_tdata,
    output logic                          m_axis_tlast
);

    localparam int R = tclc_pkg::ROWS;

    // Window and game state
    logic [tclc_pkg::ROUND_W-1:0] r_max_rounds;
    logic [R-1:0]                 r_prior_good, r_prior_bad;
    logic [R-1:0]                 r_mid_good, r_mid_bad;
    logic                         r_have_mid;
    logic                         r_seen_good, r_seen_bad;

    // Result queue
    tclc_pkg::t_result            r_fifo [tclc_pkg::FIFO_DEPTH];
    logic [tclc_pkg::FIFO_AW-1:0] r_rd_ptr, r_wr_ptr;
    logic [tclc_pkg::FIFO_CW-1:0] r_count;

    logic [tclc_pkg::FIFO_AW-1:0] n_rd_ptr, n_wr_ptr;
    logic [tclc_pkg::FIFO_CW-1:0] n_count;

    logic                          in_xfer, out_xfer;
    logic [R-1:0]                  new_good, new_bad;
    logic [tclc_pkg::ROUND_W-1:0]  round_in;
    logic                          player_in;
    logic [R-1:0]                  end_left_good, end_left_bad;
    logic [R-1:0]                  mid_res_good, mid_res_bad;
    logic [R-1:0]                  end_res_good, end_res_bad;
    logic [tclc_pkg::NROUND_W-1:0] next_round;
    logic                          seen_good, seen_bad;
    tclc_pkg::t_winner             winner;
    tclc_pkg::t_result             res_mid, res_end, res_first;
    logic [1:0]                    n_wr;
    tclc_pkg::t_result             head;

    // Unpack the input transfer
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_xfer  = m_axis_tvalid && m_axis_tready;
    assign new_good  = s_axis_tdata[R-1:0];
    assign new_bad   = s_axis_tdata[tclc_pkg::COL_W +: R];
    assign round_in  = s_axis_tdata[2*tclc_pkg::COL_W +: tclc_pkg::ROUND_W];
    assign player_in = s_axis_tdata[2*tclc_pkg::COL_W + tclc_pkg::ROUND_W];

    // Column before the new one, with the new one on its right
    tclc_column u_col_mid (
        .i_left_good  (r_prior_good),
        .i_left_bad   (r_prior_bad),
        .i_mid_good   (r_mid_good),
        .i_mid_bad    (r_mid_bad),
        .i_right_good (new_good),
        .i_right_bad  (new_bad),
        .o_good       (mid_res_good),
        .o_bad        (mid_res_bad)
    );

    // New column as the last one, dead space on its right
    assign end_left_good = r_have_mid ? r_mid_good : '0;
    assign end_left_bad  = r_have_mid ? r_mid_bad  : '0;

    tclc_column u_col_end (
        .i_left_good  (end_left_good),
        .i_left_bad   (end_left_bad),
        .i_mid_good   (new_good),
        .i_mid_bad    (new_bad),
        .i_right_good ('0),
        .i_right_bad  ('0),
        .o_good       (end_res_good),
        .o_bad        (end_res_bad)
    );

    // Merge: fold both columns into the seen flags and decide the winner
    assign next_round = tclc_pkg::NROUND_W'(round_in) + 1'b1;
    assign seen_good  = r_seen_good || (r_have_mid && (|mid_res_good)) || (|end_res_good);
    assign seen_bad   = r_seen_bad  || (r_have_mid && (|mid_res_bad))  || (|end_res_bad);

    always_comb begin
        if (!seen_bad && seen_good) begin
            winner = tclc_pkg::WIN_GOOD;
        end else if (!seen_good && seen_bad) begin
            winner = tclc_pkg::WIN_BAD;
        end else if (!seen_bad || next_round >= tclc_pkg::NROUND_W'(r_max_rounds)) begin
            winner = tclc_pkg::WIN_DRAW;
        end else begin
            winner = tclc_pkg::WIN_NONE;
        end
    end

    // Build the result items
    always_comb begin
        res_mid             = '0;
        res_mid.good        = tclc_pkg::COL_W'(mid_res_good);
        res_mid.bad         = tclc_pkg::COL_W'(mid_res_bad);
        res_mid.winner      = tclc_pkg::WIN_NONE;

        res_end             = '0;
        res_end.good        = tclc_pkg::COL_W'(end_res_good);
        res_end.bad         = tclc_pkg::COL_W'(end_res_bad);
        res_end.last        = 1'b1;
        res_end.winner      = winner;
        res_end.next_round  = next_round;
        res_end.next_player = !player_in;

        res_first = r_have_mid ? res_mid : res_end;
        n_wr      = {1'b0, in_xfer && r_have_mid} + {1'b0, in_xfer && s_axis_tlast};
    end

    // Advance queue pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr + tclc_pkg::FIFO_AW'(n_wr);
        n_rd_ptr = r_rd_ptr + tclc_pkg::FIFO_AW'(out_xfer);
        n_count  = r_count + tclc_pkg::FIFO_CW'(n_wr) - tclc_pkg::FIFO_CW'(out_xfer);
    end

    // Hold window, flags, config and queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rounds <= tclc_pkg::MAX_ROUNDS_RST;
            r_prior_good <= '0;
            r_prior_bad  <= '0;
            r_mid_good   <= '0;
            r_mid_bad    <= '0;
            r_have_mid   <= 1'b0;
            r_seen_good  <= 1'b0;
            r_seen_bad   <= 1'b0;
            r_rd_ptr     <= '0;
            r_wr_ptr     <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_rounds <= i_cfg_wdata;
            end
            if (in_xfer) begin
                if (s_axis_tlast) begin
                    r_prior_good <= '0;
                    r_prior_bad  <= '0;
                    r_mid_good   <= '0;
                    r_mid_bad    <= '0;
                    r_have_mid   <= 1'b0;
                    r_seen_good  <= 1'b0;
                    r_seen_bad   <= 1'b0;
                end else begin
                    r_prior_good <= end_left_good;
                    r_prior_bad  <= end_left_bad;
                    r_mid_good   <= new_good;
                    r_mid_bad    <= new_bad;
                    r_have_mid   <= 1'b1;
                    r_seen_good  <= r_seen_good || (r_have_mid && (|mid_res_good));
                    r_seen_bad   <= r_seen_bad  || (r_have_mid && (|mid_res_bad));
                end
            end
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    // Write results into the queue
    always_ff @(posedge i_clk) begin
        if (n_wr != 2'd0) begin
            r_fifo[r_wr_ptr] <= res_first;
        end
        if (n_wr == 2'd2) begin
            r_fifo[r_wr_ptr + 1'b1] <= res_end;
        end
    end

    // Drive the output channel from the queue head
    assign head          = r_fifo[r_rd_ptr];
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tlast  = head.last;
    assign m_axis_tdata  = tclc_pkg::OUT_W'({head.next_player, head.next_round,
                                             head.winner, head.bad, head.good});
    assign s_axis_tready = (r_count <= tclc_pkg::FIFO_CW'(tclc_pkg::FIFO_DEPTH - tclc_pkg::MAX_RES));

endmodule

/* rtl/tclc_checker.sv */
// tclc_checker: port-level assertions for two_color_life_column_step.
// Attached to the top level by the bind statement at the end of this file.
module tclc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A last column always leaves a result waiting
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
        else $error("no result after last column transfer");

    // Non-final results carry no game report
    a_mid_no_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[47:32] == 16'd0)
        else $error("game report on a non-final result");

    // A final result always carries a nonzero next round
    a_final_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[44:34] != 11'd0)
        else $error("final result with next round of zero");

    // A bad win means no good cell anywhere, the final column included
    a_bad_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast && m_axis_tdata[33:32] == 2'd2
        |-> m_axis_tdata[15:0] == 16'd0)
        else $error("bad side wins with good cells present");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind two_color_life_column_step tclc_checker u_tclc_checker (.*);

/* tb/sv/tb_two_color_life_column_step.sv */
`timescale 1ns / 1ps
// tb_two_color_life_column_step: self-checking bench for the two-color Life column stepper.
// Predicts every result column in a small tracker class and compares it field by field.
// Depends on tclc_pkg and the two_color_life_column_step RTL.

module tb_two_color_life_column_step;

    localparam int LONG_HOLD     = 200;
    localparam int PHASE_COLUMNS = 190;

    typedef enum int {MIXED, DISJOINT, GOOD_ONLY, BAD_ONLY, EMPTY_BOARD} t_board_kind;

    // Window, seen flags and round limit of the block, plus the queue of expected result columns
    class t_gen_tracker;
        logic [tclc_pkg::COL_W-1:0]   left_good = '0, left_bad = '0, mid_good = '0, mid_bad = '0;
        bit                           have_mid = 1'b0, seen_good = 1'b0, seen_bad = 1'b0;
        logic [tclc_pkg::ROUND_W-1:0] round_limit = tclc_pkg::MAX_ROUNDS_RST;
        tclc_pkg::t_result            pending_q[$];
        int                 mismatches = 0, columns_in = 0, boards_in = 0, results_out = 0;
        int                 winner_tally[4] = '{0, 0, 0, 0};

        // Next generation of the middle column; rows outside the board are dead
        function void evolve(input logic [tclc_pkg::COL_W-1:0] lg, lb, mg, mb, rg, rb,
                             output logic [tclc_pkg::COL_W-1:0] og, ob);
            logic [tclc_pkg::COL_W+1:0] la, lgp, ma, mgp, ra, rgp;
            int live, good;
            la  = {1'b0, lg | lb, 1'b0};
            lgp = {1'b0, lg, 1'b0};
            ma  = {1'b0, mg | mb, 1'b0};
            mgp = {1'b0, mg, 1'b0};
            ra  = {1'b0, rg | rb, 1'b0};
            rgp = {1'b0, rg, 1'b0};
            og = '0;
            ob = '0;
            for (int r = 0; r < tclc_pkg::ROWS; r++) begin
                live = $countones({la[r +: 3], ma[r], ma[r+2], ra[r +: 3]});
                good = $countones({lgp[r +: 3], mgp[r], mgp[r+2], rgp[r +: 3]});
                if (mg[r] | mb[r]) begin
                    // a cell of both colors never survives
                    if ((live == 2 || live == 3) && !(mg[r] && mb[r])) begin
                        if (mg[r]) og[r] = 1'b1;
                        else ob[r] = 1'b1;
                    end
                end else if (live == 3) begin
                    if (good >= 2) og[r] = 1'b1;
                    else ob[r] = 1'b1;
                end
            end
        endfunction

        // Record one result column; the final one carries the verdict of the generation
        function void queue_result(logic [tclc_pkg::COL_W-1:0] g, b, logic fin,
                                   logic [tclc_pkg::NROUND_W-1:0] nr, logic np);
            tclc_pkg::t_result res;
            if (g != '0) seen_good = 1'b1;
            if (b != '0) seen_bad = 1'b1;
            res.good        = g;
            res.bad         = b;
            res.last        = fin;
            res.winner      = tclc_pkg::WIN_NONE;
            res.next_round  = '0;
            res.next_player = 1'b0;
            if (fin) begin
                if (seen_good && !seen_bad) res.winner = tclc_pkg::WIN_GOOD;
                else if (seen_bad && !seen_good) res.winner = tclc_pkg::WIN_BAD;
                else if (!seen_bad || nr >= round_limit) res.winner = tclc_pkg::WIN_DRAW;
                res.next_round  = nr;
                res.next_player = np;
                winner_tally[int'(res.winner)]++;
            end
            pending_q = {pending_q, res};
        endfunction

        // Advance the window by one accepted input column
        function void note_column(logic [tclc_pkg::COL_W-1:0] g, b, logic fin,
                                  logic [tclc_pkg::ROUND_W-1:0] rnd, logic plyr);
            logic [tclc_pkg::COL_W-1:0] ng, nb;
            columns_in++;
            if (have_mid) begin
                evolve(left_good, left_bad, mid_good, mid_bad, g, b, ng, nb);
                queue_result(ng, nb, 1'b0, '0, 1'b0);
                left_good = mid_good;
                left_bad  = mid_bad;
            end else begin
                left_good = '0;
                left_bad  = '0;
            end
            mid_good = g;
            mid_bad  = b;
            have_mid = 1'b1;
            if (fin) begin
                evolve(left_good, left_bad, mid_good, mid_bad, '0, '0, ng, nb);
                queue_result(ng, nb, 1'b1, tclc_pkg::NROUND_W'(rnd) + 1'b1, ~plyr);
                left_good = '0;
                left_bad  = '0;
                mid_good  = '0;
                mid_bad   = '0;
                have_mid  = 1'b0;
                seen_good = 1'b0;
                seen_bad  = 1'b0;
                boards_in++;
            end
        endfunction

        function void compare(string field, logic [tclc_pkg::COL_W-1:0] want,
                              logic [tclc_pkg::COL_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, actual %0h", field, want, got);
                mismatches++;
            end
        endfunction

        // Check one result transfer against the oldest expected column
        function void check_result(logic [tclc_pkg::OUT_W-1:0] data, logic fin);
            tclc_pkg::t_result want;
            results_out++;
            if (pending_q.size() == 0) begin
                $error("result transfer with nothing expected: tdata=%h tlast=%b", data, fin);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            compare("next_good_column", want.good, data[15:0]);
            compare("next_bad_column", want.bad, data[31:16]);
            compare("final_column", want.last, fin);
            compare("winner", want.winner, data[33:32]);
            compare("next_round", want.next_round, data[44:34]);
            compare("next_player", want.next_player, data[45]);
            compare("tdata padding", '0, data[47:46]);
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [tclc_pkg::ROUND_W-1:0] i_cfg_wdata;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    // [15:0] good_column, [31:16] bad_column, [41:32] round_number, [42] side_to_move
    logic [tclc_pkg::IN_W-1:0]    s_axis_tdata;
    logic                         s_axis_tlast;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    // [15:0] next_good_column, [31:16] next_bad_column, [33:32] winner,
    // [44:34] next_round, [45] next_player
    logic [tclc_pkg::OUT_W-1:0]   m_axis_tdata;
    logic                         m_axis_tlast;

    logic hold_start = 1'b0;
    int   hold_left = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    t_gen_tracker tracker = new();

    two_color_life_column_step DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Count down a long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_start) hold_left <= LONG_HOLD;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    // Check each result transfer, then pick the next ready value
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata, m_axis_tlast);
        m_axis_tready <= (hold_left == 0) && !hold_start &&
                         ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one column and hold it until the transfer
    task automatic send_column(logic [tclc_pkg::COL_W-1:0] g, b, logic fin,
                               logic [tclc_pkg::ROUND_W-1:0] rnd, logic plyr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, plyr, rnd, b, g};
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_column(g, b, fin, rnd, plyr);
    endtask

    // Drop valid and wait until every expected column has come out
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_round_limit(logic [tclc_pkg::ROUND_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.round_limit = value;
    endtask

    function automatic logic [tclc_pkg::COL_W-1:0] random_cells();
        case ($urandom_range(9))
            0: return '1;
            1: return '0;
            2: return tclc_pkg::COL_W'(1) << $urandom_range(tclc_pkg::COL_W-1);
            3, 4: return tclc_pkg::COL_W'($urandom);
            5, 6, 7: return tclc_pkg::COL_W'($urandom & $urandom);
            default: return tclc_pkg::COL_W'($urandom & $urandom & $urandom);
        endcase
    endfunction

    task automatic send_board(int width, t_board_kind kind,
                              logic [tclc_pkg::ROUND_W-1:0] rnd, logic plyr);
        logic [tclc_pkg::COL_W-1:0] g, b;
        for (int c = 0; c < width; c++) begin
            g = random_cells();
            b = random_cells();
            case (kind)
                DISJOINT:    b = b & ~g;
                GOOD_ONLY:   b = '0;
                BAD_ONLY:    g = '0;
                EMPTY_BOARD: begin
                    g = '0;
                    b = '0;
                end
                default: ;
            endcase
            send_column(g, b, c == width - 1, rnd, plyr);
        end
    endtask

    // Whole boards with random content; rounds often sit right at the draw limit
    task automatic run_random_boards(int columns);
        int sent, width, pick, near;
        t_board_kind kind;
        logic [tclc_pkg::ROUND_W-1:0] rnd;
        sent = 0;
        while (sent < columns) begin
            width = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
            pick = $urandom_range(9);
            if (pick < 5) kind = MIXED;
            else if (pick < 7) kind = DISJOINT;
            else if (pick == 7) kind = GOOD_ONLY;
            else if (pick == 8) kind = BAD_ONLY;
            else kind = EMPTY_BOARD;
            case ($urandom_range(3))
                0: begin
                    near = int'(tracker.round_limit) - 3 + int'($urandom_range(4));
                    if (near < 0) near = 0;
                    if (near > 1023) near = 1023;
                    rnd = tclc_pkg::ROUND_W'(near);
                end
                1: rnd = $urandom_range(1) ? '1 : '0;
                default: rnd = tclc_pkg::ROUND_W'($urandom);
            endcase
            send_board(width, kind, rnd, 1'($urandom_range(1)));
            sent += width;
        end
    endtask

    initial begin : stimulus
        logic [tclc_pkg::ROUND_W-1:0] limit_v;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed boards under the reset round limit
        // lone columns: interior rows survive, edge rows die; top round wraps into bit 10
        send_column('1, '0, 1'b1, 10'd0, 1'b0);
        send_column('0, '1, 1'b1, 10'd1023, 1'b1);
        // empty board is a draw
        send_column('0, '0, 1'b0, 10'd5, 1'b0);
        send_column('0, '0, 1'b1, 10'd5, 1'b0);
        // every cell of both colors: all die
        send_column('1, '1, 1'b0, 10'd98, 1'b1);
        send_column('1, '1, 1'b0, 10'd98, 1'b1);
        send_column('1, '1, 1'b1, 10'd98, 1'b1);
        // good blinker turns over
        send_column(16'h0020, '0, 1'b0, 10'd42, 1'b0);
        send_column(16'h0020, '0, 1'b0, 10'd42, 1'b0);
        send_column(16'h0020, '0, 1'b1, 10'd42, 1'b0);
        // good-majority births beside a bad survivor, round hits the limit
        send_column(16'h0020, '0, 1'b0, 10'd99, 1'b1);
        send_column('0, 16'h0020, 1'b0, 10'd99, 1'b1);
        send_column(16'h0020, '0, 1'b1, 10'd99, 1'b1);
        // bad-majority births beside a good survivor, below the limit
        send_column('0, 16'h0020, 1'b0, 10'd97, 1'b0);
        send_column(16'h0020, '0, 1'b0, 10'd97, 1'b0);
        send_column('0, 16'h0020, 1'b1, 10'd97, 1'b0);
        // top and bottom rows occupied: nothing wraps
        send_column(16'h8001, 16'h4002, 1'b0, 10'd0, 1'b1);
        send_column(16'hC003, '0, 1'b0, 10'd0, 1'b1);
        send_column('0, 16'h8001, 1'b1, 10'd0, 1'b1);
        wait_idle();

        // Random phases: round limit and idling pattern change between them
        for (int p = 0; p < 8; p++) begin
            case (p)
                0, 6:    limit_v = 10'd1;
                1, 4:    limit_v = 10'd1023;
                3:       limit_v = 10'd100;
                default: limit_v = tclc_pkg::ROUND_W'($urandom_range(1022, 2));
            endcase
            write_round_limit(limit_v);
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct = 66;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 66;
                end
                default: begin
                    send_idle_pct = 6;
                    recv_stall_pct <= 6;
                end
            endcase
            // fill the result queue against a long receiver hold-off
            if (p == 4) begin
                hold_start <= 1'b1;
                @(posedge i_clk);
                hold_start <= 1'b0;
            end
            run_random_boards(PHASE_COLUMNS);
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        $display("covered %0d columns in %0d boards, %0d results checked, %0d mismatches",
                 tracker.columns_in, tracker.boards_in, tracker.results_out, tracker.mismatches);
        $display("verdicts: none %0d, good %0d, bad %0d, draw %0d; round limits 1, 100, 1023",
                 tracker.winner_tally[0], tracker.winner_tally[1], tracker.winner_tally[2],
                 tracker.winner_tally[3]);
        if (tracker.mismatches == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tclc_pkg.sv
rtl/tclc_lane.sv
rtl/tclc_column.sv
rtl/two_color_life_column_step.sv
rtl/tclc_checker.sv
tb/sv/tb_two_color_life_column_step.sv
